/* design/hzwc_pkg.sv */
// Shared types, constants and command/status bundles for the hit z-bin classifier.
package hzwc_pkg;

    localparam int BIN_W    = 6;
    localparam int NB_W     = 7;
    localparam int OV_W     = 10;
    localparam int LAYER_W  = 3;
    localparam int PHI_W    = 19;
    localparam int Z_W      = 20;
    localparam int CFG_W    = 10;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    localparam int NUM_W    = 42;
    localparam int DEN_W    = 23;
    localparam int QUO_W    = 24;
    localparam int RES_W    = 25;
    localparam int EDGE_W   = 18;

    localparam logic [0:0] REG_NUM_BINS = 1'b0;
    localparam logic [0:0] REG_OVERLAP  = 1'b1;

    localparam logic [EDGE_W-1:0] EDGE_MIN  = 18'd3277;
    localparam logic [EDGE_W-1:0] EDGE_MAX  = 18'd160563;
    localparam logic [EDGE_W-1:0] EDGE_LOW  = 18'd16384;
    localparam logic [EDGE_W-1:0] EDGE_HIGH = 18'd147456;
    localparam logic [EDGE_W-1:0] Q16_2P5   = 18'd163840;

    localparam logic [1:0] OP_ER = 2'd0;
    localparam logic [1:0] OP_EL = 2'd1;
    localparam logic [1:0] OP_UP = 2'd2;
    localparam logic [1:0] OP_LO = 2'd3;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic       cap;
        logic [1:0] op;
        logic       bin_next;
        logic       take_bin;
        logic       push;
        logic       push_last;
        logic       clr_pend;
    } hzwc_cmd_t;

    typedef struct packed {
        logic layer_ok;
        logic div_done;
        logic hit;
        logic last_i;
        logic pend_valid;
        logic out_free;
    } hzwc_sts_t;

endpackage

/* design/hzwc_div.sv */
// Sequential floor divider: signed numerator by positive divisor, one quotient bit a cycle.
module hzwc_div
    import hzwc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [NUM_W-1:0]  numer,
    input  logic        [DEN_W-1:0]  denom,
    output logic                     done,
    output logic signed [RES_W-1:0]  quot
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_PREP = 2'd1;
    localparam logic [1:0] D_RUN  = 2'd2;

    logic [1:0]              phase_reg;
    logic [4:0]              cnt_reg;
    logic                    done_reg;
    logic signed [NUM_W-1:0] n_reg;
    logic [DEN_W-1:0]        d_reg;
    logic                    neg_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [QUO_W-1:0]        sh_reg;

    logic [NUM_W-1:0] mag;
    logic [DEN_W:0]   trial;
    logic             qbit;

    always_comb begin
        if (n_reg < 0) begin
            mag = NUM_W'(-n_reg) + NUM_W'(d_reg) - NUM_W'(1);
        end else begin
            mag = NUM_W'(n_reg);
        end
        trial = {rem_reg, sh_reg[QUO_W-1]};
        qbit  = (trial >= {1'b0, d_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            case (phase_reg)
                D_IDLE: begin
                    if (start) begin
                        n_reg     <= numer;
                        d_reg     <= denom;
                        phase_reg <= D_PREP;
                    end
                end
                D_PREP: begin
                    neg_reg   <= (n_reg < 0);
                    rem_reg   <= DEN_W'(mag[NUM_W-2:QUO_W]);
                    sh_reg    <= mag[QUO_W-1:0];
                    cnt_reg   <= 5'(QUO_W - 1);
                    phase_reg <= D_RUN;
                end
                D_RUN: begin
                    if (qbit) begin
                        rem_reg <= DEN_W'(trial - {1'b0, d_reg});
                    end else begin
                        rem_reg <= DEN_W'(trial);
                    end
                    sh_reg <= {sh_reg[QUO_W-2:0], qbit};
                    if (cnt_reg == 5'd0) begin
                        phase_reg <= D_IDLE;
                        done_reg  <= 1'b1;
                    end else begin
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                default: phase_reg <= D_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, sh_reg}) : $signed({1'b0, sh_reg});

endmodule

/* design/hzwc_datapath.sv */
// Datapath: config registers, edge and bound arithmetic, bin test and result register.
module hzwc_datapath
    import hzwc_pkg::*;
#(
    parameter int MAX_BINS   = 64,
    parameter int NUM_LAYERS = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    input  hzwc_cmd_t           cmd,
    output hzwc_sts_t           sts
);

    logic [NB_W-1:0]          nbins_reg;
    logic [OV_W-1:0]          ov_reg;
    logic [LAYER_W-1:0]       layer_reg;
    logic [PHI_W-1:0]         phi_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic [BIN_W-1:0]         bin_reg;
    logic [EDGE_W-1:0]        re_reg;
    logic [EDGE_W-1:0]        le_reg;
    logic signed [RES_W-1:0]  hi_reg;
    logic signed [RES_W-1:0]  lo_reg;
    logic [BIN_W-1:0]         pend_reg;
    logic                     pend_valid_reg;
    logic                     out_valid_reg;
    logic [BIN_W-1:0]         out_bin_reg;
    logic [LAYER_W-1:0]       out_layer_reg;
    logic [PHI_W-1:0]         out_phi_reg;
    logic [Z_W-1:0]           out_z_reg;
    logic                     out_last_reg;

    logic [NB_W-1:0]          nb_eff;
    logic [3:0]               k;
    logic signed [17:0]       edge_arg;
    logic [EDGE_W-1:0]        e;
    logic                     e_low;
    logic                     e_high;
    logic [EDGE_W-1:0]        ex;
    logic signed [NUM_W-1:0]  mid_n;
    logic signed [NUM_W-1:0]  big;
    logic signed [NUM_W-1:0]  kk;
    logic [5:0]               coef;
    logic signed [NUM_W-1:0]  numer;
    logic [DEN_W-1:0]         denom;
    logic                     div_done;
    logic signed [RES_W-1:0]  quot;
    logic [EDGE_W-1:0]        q_clamp;
    logic signed [RES_W-1:0]  z_ext;

    always_comb begin
        if (nbins_reg == '0) begin
            nb_eff = NB_W'(1);
        end else if (nbins_reg > NB_W'(MAX_BINS)) begin
            nb_eff = NB_W'(MAX_BINS);
        end else begin
            nb_eff = nbins_reg;
        end
        k = 4'({1'b0, layer_reg}) + 4'd1;

        if (cmd.op == OP_ER) begin
            edge_arg = $signed({3'b0, bin_reg, 9'h100}) - $signed({8'b0, ov_reg});
        end else begin
            edge_arg = $signed({3'b0, bin_reg, 9'h100}) + $signed({8'b0, ov_reg});
        end

        e      = (cmd.op == OP_UP) ? re_reg : le_reg;
        e_low  = (e < EDGE_LOW);
        e_high = (e > EDGE_HIGH);
        ex     = e_low ? e : (Q16_2P5 - e);

        if (cmd.op == OP_UP) begin
            mid_n = 42'sd491520
                  + $signed(NUM_W'(k)) * (42'sd720896 - $signed(NUM_W'(e)) * 42'sd10);
        end else begin
            mid_n = -42'sd491520
                  + $signed(NUM_W'(k)) * (42'sd917504 - $signed(NUM_W'(e)) * 42'sd10);
        end
        big  = 42'sd3932160 * $signed(NUM_W'(ex));
        coef = (((cmd.op == OP_UP) && e_low) || ((cmd.op == OP_LO) && !e_low)) ? 6'd17 : 6'd23;
        kk   = $signed(NUM_W'(k) * NUM_W'(coef)) <<< 32;

        case (cmd.op)
            OP_ER, OP_EL: begin
                numer = $signed(NUM_W'(edge_arg)) * 42'sd320;
                denom = DEN_W'(nb_eff);
            end
            OP_UP: begin
                if (!e_low && !e_high) begin
                    numer = mid_n;
                    denom = DEN_W'(50);
                end else begin
                    numer = big + kk;
                    denom = DEN_W'(ex) * DEN_W'(400);
                end
            end
            default: begin
                if (!e_low && !e_high) begin
                    numer = mid_n;
                    denom = DEN_W'(50);
                end else if (e_low) begin
                    numer = kk - big;
                    denom = DEN_W'(ex) * DEN_W'(400);
                end else begin
                    numer = -big - kk;
                    denom = DEN_W'(ex) * DEN_W'(400);
                end
            end
        endcase

        if (quot > $signed(RES_W'(EDGE_MAX))) begin
            q_clamp = EDGE_MAX;
        end else if (quot < $signed(RES_W'(EDGE_MIN))) begin
            q_clamp = EDGE_MIN;
        end else begin
            q_clamp = quot[EDGE_W-1:0];
        end
        z_ext = RES_W'(z_reg);
    end

    hzwc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .numer   (numer),
        .denom   (denom),
        .done    (div_done),
        .quot    (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nbins_reg      <= NB_W'(64);
            ov_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_NUM_BINS: nbins_reg <= cfg_data[NB_W-1:0];
                    REG_OVERLAP:  ov_reg    <= cfg_data[OV_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load || cmd.clr_pend) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.take_bin) begin
                pend_valid_reg <= 1'b1;
            end
            if (cmd.push) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            layer_reg <= s_tdata[2:0];
            phi_reg   <= s_tdata[21:3];
            z_reg     <= s_tdata[41:22];
            bin_reg   <= '0;
        end else if (cmd.bin_next) begin
            bin_reg <= bin_reg + BIN_W'(1);
        end
        if (cmd.cap) begin
            case (cmd.op)
                OP_ER:   re_reg <= q_clamp;
                OP_EL:   le_reg <= q_clamp;
                OP_UP:   hi_reg <= quot;
                default: lo_reg <= quot;
            endcase
        end
        if (cmd.take_bin) begin
            pend_reg <= bin_reg;
        end
        if (cmd.push) begin
            out_bin_reg   <= pend_reg;
            out_layer_reg <= layer_reg;
            out_phi_reg   <= phi_reg;
            out_z_reg     <= z_reg;
            out_last_reg  <= cmd.push_last;
        end
    end

    assign sts.layer_ok   = ({1'b0, layer_reg} < (LAYER_W+1)'(NUM_LAYERS));
    assign sts.div_done   = div_done;
    assign sts.hit        = (z_ext < hi_reg) && (z_ext > lo_reg);
    assign sts.last_i     = ({1'b0, bin_reg} == nb_eff - NB_W'(1));
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_z_reg, out_phi_reg, out_layer_reg, out_bin_reg};

endmodule

/* design/hzwc_ctrl.sv */
// Controller: sequences the four divisions per bin, the bin test and result pushes.
module hzwc_ctrl
    import hzwc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output hzwc_cmd_t cmd,
    input  hzwc_sts_t sts
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_ER_S  = 4'd2;
    localparam logic [3:0] ST_ER_W  = 4'd3;
    localparam logic [3:0] ST_EL_S  = 4'd4;
    localparam logic [3:0] ST_EL_W  = 4'd5;
    localparam logic [3:0] ST_UP_S  = 4'd6;
    localparam logic [3:0] ST_UP_W  = 4'd7;
    localparam logic [3:0] ST_LO_S  = 4'd8;
    localparam logic [3:0] ST_LO_W  = 4'd9;
    localparam logic [3:0] ST_TEST  = 4'd10;
    localparam logic [3:0] ST_PUSH  = 4'd11;
    localparam logic [3:0] ST_FLUSH = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [3:0] adv_state;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        adv_state  = sts.last_i ? ST_FLUSH : ST_ER_S;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: state_next = sts.layer_ok ? ST_ER_S : ST_IDLE;
            ST_ER_S: begin
                cmd.op = OP_ER; cmd.div_start = 1'b1; state_next = ST_ER_W;
            end
            ST_ER_W: begin
                cmd.op = OP_ER;
                if (sts.div_done) begin
                    cmd.cap = 1'b1; state_next = ST_EL_S;
                end
            end
            ST_EL_S: begin
                cmd.op = OP_EL; cmd.div_start = 1'b1; state_next = ST_EL_W;
            end
            ST_EL_W: begin
                cmd.op = OP_EL;
                if (sts.div_done) begin
                    cmd.cap = 1'b1; state_next = ST_UP_S;
                end
            end
            ST_UP_S: begin
                cmd.op = OP_UP; cmd.div_start = 1'b1; state_next = ST_UP_W;
            end
            ST_UP_W: begin
                cmd.op = OP_UP;
                if (sts.div_done) begin
                    cmd.cap = 1'b1; state_next = ST_LO_S;
                end
            end
            ST_LO_S: begin
                cmd.op = OP_LO; cmd.div_start = 1'b1; state_next = ST_LO_W;
            end
            ST_LO_W: begin
                cmd.op = OP_LO;
                if (sts.div_done) begin
                    cmd.cap = 1'b1; state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (sts.hit && sts.pend_valid) begin
                    state_next = ST_PUSH;
                end else begin
                    cmd.take_bin = sts.hit;
                    cmd.bin_next = !sts.last_i;
                    state_next   = adv_state;
                end
            end
            ST_PUSH: begin
                if (sts.out_free) begin
                    cmd.push     = 1'b1;
                    cmd.take_bin = 1'b1;
                    cmd.bin_next = !sts.last_i;
                    state_next   = adv_state;
                end
            end
            ST_FLUSH: begin
                if (!sts.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.push      = 1'b1;
                    cmd.push_last = 1'b1;
                    cmd.clr_pend  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/hit_zbin_window_classifier_core.sv */
// Top level of the hit z-bin window classifier: controller plus datapath.
// Each bin takes four divisions on the shared bit-serial divider and a bin test;
// each accepted bin after the first adds a push state, and output stalls add to the
// time that one hit takes.
// Throughput: one hit at a time; the next hit is taken once the last bin is tested
// and its final result, if any, is loaded into the output register.
// Reset: synchronous active-low aresetn; num_bins returns to 64, overlap to 0.
module hit_zbin_window_classifier_core
    import hzwc_pkg::*;
#(
    parameter int MAX_BINS   = 64,
    parameter int NUM_LAYERS = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // layer[2:0], phi[21:3], z[41:22]
    output logic                m_tvalid,
    input  logic                m_tready,
    // bin_index[5:0], hit_layer[8:6], hit_phi[27:9], hit_z[47:28]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    hzwc_cmd_t cmd;
    hzwc_sts_t sts;

    hzwc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    hzwc_datapath #(
        .MAX_BINS   (MAX_BINS),
        .NUM_LAYERS (NUM_LAYERS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* design/hzwc_checker.sv */
// Port-level checker for the hit z-bin classifier and its bind to the top level.
module hzwc_checker
    import hzwc_pkg::*;
#(
    parameter int MAX_BINS   = 64,
    parameter int NUM_LAYERS = 5
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled item changed");

    a_layer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_tdata[8:6]) < NUM_LAYERS))
        else $error("result from out-of-range layer");

    a_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_tdata[5:0]) < MAX_BINS))
        else $error("bin index out of range");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while a hit is in work");

endmodule

bind hit_zbin_window_classifier_core hzwc_checker #(
    .MAX_BINS   (MAX_BINS),
    .NUM_LAYERS (NUM_LAYERS)
) u_hzwc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
